@@ rtl/tpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tpq_pkg: shared types and codes for the three-class priority queue
// Beat payload structs, status codes and class codes.
// ----------------------------------------------------------------------------
package tpq_pkg;

	localparam int NUM_CLASSES     = 3;
	localparam int DEF_CLASS_DEPTH = 16;
	localparam int DEF_ID_BITS     = 16;

	// actions
	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	// classes
	localparam logic [1:0] CLS_LOW  = 2'd0;
	localparam logic [1:0] CLS_MID  = 2'd1;
	localparam logic [1:0] CLS_HIGH = 2'd2;
	localparam logic [1:0] CLS_NONE = 2'd3;

	// result status
	localparam logic [2:0] ST_ENQ   = 3'd0;
	localparam logic [2:0] ST_DUP   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_DEQ   = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic        action;
		logic [15:0] entry_id;
		logic [1:0]  entry_class;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_id;
		logic [1:0]  out_class;
		logic        head_valid;
		logic [15:0] head_id;
		logic [1:0]  head_class;
	} rsp_t;

endpackage

@@ rtl/tpq_ram.sv @@
// ----------------------------------------------------------------------------
// tpq_ram: id store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tpq_ram #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/three_class_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// three_class_priority_queue_top: strict-priority queue, three FIFO classes
// Request beats enqueue or dequeue; every request yields one response beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req): action 0 enqueues entry_id into
//   class entry_class (0 low, 1 middle, 2 high); action 1 dequeues the front
//   of the highest non-empty class.
//   rsp channel (rsp_valid/rsp_ready/rsp): status, dequeued id and class, and
//   the entry that will be served next (head_valid/head_id/head_class).
// Operation:
//   One request at a time; an enqueue scans every queued id for a duplicate,
//   one id store read a cycle, covering every id queued over all classes
//   (up to 3 * CLASS_DEPTH). A dequeue reads the front id of the top class,
//   then the new head. The id store's single read port serialises all reads.
// Reset:
//   All classes empty. The id store is not cleared; only occupied slots are
//   ever read, so no clearing pass is needed.
// Stall:
//   The response sits in an output register. A new request is accepted while
//   it waits; that request's result holds in the done state until the
//   output register frees up.
// ----------------------------------------------------------------------------
module three_class_priority_queue_top
	import tpq_pkg::*;
#(
	parameter int CLASS_DEPTH = DEF_CLASS_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int NSLOT = NUM_CLASSES * CLASS_DEPTH;
	localparam int AW    = $clog2(NSLOT);
	localparam int PW    = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
	localparam int CW    = $clog2(CLASS_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_DEQ,
		S_DEQ_CAP,
		S_HEAD_RD,
		S_HEAD_CAP,
		S_DONE
	} state_t;

	// pointer increment, wraps at CLASS_DEPTH
	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(CLASS_DEPTH - 1)) ? '0 : PW'(p + 1'b1);
	endfunction

	// flat slot address of (class, pointer)
	function automatic logic [AW-1:0] slot_of(input logic [1:0] c, input logic [PW-1:0] p);
		return AW'(AW'(c) * AW'(CLASS_DEPTH) + AW'(p));
	endfunction

	state_t           state_q;
	logic [PW-1:0]    head_q [NUM_CLASSES];
	logic [PW-1:0]    tail_q [NUM_CLASSES];
	logic [CW-1:0]    cnt_q  [NUM_CLASSES];

	// current request
	logic [ID_BITS-1:0] id_q;
	logic [1:0]         cls_q;

	// duplicate scan
	logic [1:0]    sc_q;
	logic [PW-1:0] sp_q;
	logic [CW-1:0] sr_q;
	logic          rd_v_s1;
	logic          dup_q;

	// result being built
	logic [2:0]         st_q;
	logic [ID_BITS-1:0] oid_q;
	logic [1:0]         ocls_q;
	logic               hv_q;
	logic [ID_BITS-1:0] hid_q;
	logic [1:0]         hc_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// memory port signals
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ID_BITS-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;

	logic       top_v;
	logic [1:0] top_c;
	logic       cls_ok;
	logic [1:0] cls_i;
	logic       enq_ok;
	logic       hit;

	tpq_ram #(
		.DEPTH (NSLOT),
		.WIDTH (ID_BITS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (id_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// highest non-empty class
	always_comb begin
		top_v = 1'b1;
		top_c = CLS_HIGH;
		if (cnt_q[CLS_HIGH] != '0) begin
			top_c = CLS_HIGH;
		end else if (cnt_q[CLS_MID] != '0) begin
			top_c = CLS_MID;
		end else if (cnt_q[CLS_LOW] != '0) begin
			top_c = CLS_LOW;
		end else begin
			top_v = 1'b0;
			top_c = CLS_LOW;
		end
	end

	// class code three has no FIFO: answered as full
	assign cls_ok = (cls_q != CLS_NONE);
	assign cls_i  = cls_ok ? cls_q : CLS_LOW;
	assign enq_ok = cls_ok && (cnt_q[cls_i] != CW'(CLASS_DEPTH));
	assign hit    = rd_v_s1 && (rd_data == id_q);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = slot_of(cls_i, tail_q[cls_i]);
		case (state_q)
			S_SCAN: begin
				if (sr_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = slot_of(sc_q, sp_q);
				end
			end
			S_DECIDE: begin
				wr_en = !dup_q && enq_ok;
			end
			S_DEQ, S_DEQ_CAP, S_HEAD_RD: begin
				rd_en   = top_v;
				rd_addr = slot_of(top_c, head_q[top_c]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c] <= '0;
				tail_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
			id_q        <= '0;
			cls_q       <= CLS_LOW;
			sc_q        <= '0;
			sp_q        <= '0;
			sr_q        <= '0;
			rd_v_s1     <= 1'b0;
			dup_q       <= 1'b0;
			st_q        <= ST_ENQ;
			oid_q       <= '0;
			ocls_q      <= CLS_LOW;
			hv_q        <= 1'b0;
			hid_q       <= '0;
			hc_q        <= CLS_LOW;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// scan read data is valid in the cycle after issue
			rd_v_s1 <= (state_q == S_SCAN) && (sr_q != '0);
			if (hit) begin
				dup_q <= 1'b1;
			end
			// the done state reloads the output register itself
			if (rsp_valid_q && rsp_ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						id_q  <= ID_BITS'(req.entry_id);
						cls_q <= req.entry_class;
						dup_q <= 1'b0;
						sc_q  <= CLS_LOW;
						sp_q  <= head_q[CLS_LOW];
						sr_q  <= cnt_q[CLS_LOW];
						state_q <= (req.action == ACT_DEQ) ? S_DEQ : S_SCAN;
					end
				end
				S_SCAN: begin
					if (sr_q != '0) begin
						sp_q <= ptr_inc(sp_q);
						sr_q <= CW'(sr_q - 1'b1);
					end else if (sc_q == CLS_HIGH) begin
						state_q <= S_DECIDE;
					end else begin
						sc_q <= 2'(sc_q + 1'b1);
						sp_q <= head_q[2'(sc_q + 1'b1)];
						sr_q <= cnt_q[2'(sc_q + 1'b1)];
					end
				end
				S_DECIDE: begin
					oid_q  <= '0;
					ocls_q <= CLS_LOW;
					if (dup_q) begin
						st_q <= ST_DUP;
					end else if (!enq_ok) begin
						st_q <= ST_FULL;
					end else begin
						tail_q[cls_i] <= ptr_inc(tail_q[cls_i]);
						cnt_q[cls_i]  <= CW'(cnt_q[cls_i] + 1'b1);
						st_q          <= ST_ENQ;
					end
					state_q <= S_HEAD_RD;
				end
				S_DEQ: begin
					oid_q <= '0;
					if (top_v) begin
						head_q[top_c] <= ptr_inc(head_q[top_c]);
						cnt_q[top_c]  <= CW'(cnt_q[top_c] - 1'b1);
						st_q          <= ST_DEQ;
						ocls_q        <= top_c;
						state_q       <= S_DEQ_CAP;
					end else begin
						ocls_q  <= CLS_LOW;
						st_q    <= ST_EMPTY;
						state_q <= S_HEAD_RD;
					end
				end
				S_DEQ_CAP, S_HEAD_RD: begin
					// dequeued id lands now; next head read issues alongside
					if (state_q == S_DEQ_CAP) begin
						oid_q <= rd_data;
					end
					hv_q <= top_v;
					if (top_v) begin
						hc_q    <= top_c;
						state_q <= S_HEAD_CAP;
					end else begin
						hc_q    <= CLS_LOW;
						hid_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_HEAD_CAP: begin
					hid_q   <= rd_data;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q.status     <= st_q;
						rsp_q.out_id     <= 16'(oid_q);
						rsp_q.out_class  <= ocls_q;
						rsp_q.head_valid <= hv_q;
						rsp_q.head_id    <= 16'(hid_q);
						rsp_q.head_class <= hc_q;
						rsp_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
